FILE: src/kca_pkg.sv
// ----------------------------------------------------------------------------
// kca_pkg
// types, field widths and codes shared by the accumulator table and its cells
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 32;
  localparam int RIDX_W   = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int TOTAL_W  = 7;

  // common width for comparing a cell position with a read index
  localparam int CMP_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEARCH = 2'd0,
    MODE_LAST   = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_READ_BAD = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // request seen by every cell while a scan runs
  typedef struct packed {
    mode_t             op;
    logic [KEY_W-1:0]  key;
    logic [RIDX_W-1:0] ridx;
  } query_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } scan_t;

  // write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } wr_t;

endpackage

FILE: src/kca_if.sv
// ----------------------------------------------------------------------------
// kca request and result channels
// valid/ready channels carrying one request or one result
// ----------------------------------------------------------------------------
interface kca_req_if;
  logic                        valid;
  logic                        ready;
  logic [kca_pkg::MODE_W-1:0]  mode;
  logic [kca_pkg::KEY_W-1:0]   doc_id;
  logic [kca_pkg::CNT_W-1:0]   amount;
  logic [kca_pkg::RIDX_W-1:0]  read_index;

  modport source (output valid, mode, doc_id, amount, read_index, input ready);
  modport sink (input valid, mode, doc_id, amount, read_index, output ready);
endinterface

interface kca_res_if;
  logic                         valid;
  logic                         ready;
  logic [kca_pkg::STATUS_W-1:0] status;
  logic [kca_pkg::SLOT_W-1:0]   slot;
  logic [kca_pkg::KEY_W-1:0]    doc_id_out;
  logic [kca_pkg::CNT_W-1:0]    count_out;
  logic [kca_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, status, slot, doc_id_out, count_out, entry_total,
                  input ready);
  modport sink (input valid, status, slot, doc_id_out, count_out, entry_total,
                output ready);
endinterface

FILE: src/kca_cell.sv
// ----------------------------------------------------------------------------
// kca_cell
// one table entry: holds a key and a count, checks the passing scan token
// ----------------------------------------------------------------------------
module kca_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kca_pkg::IDX_W-1:0]     pos,
  input  logic [kca_pkg::USED_W-1:0]    used,
  input  kca_pkg::query_t               query,
  input  kca_pkg::wr_t                  wr,
  input  kca_pkg::scan_t                scan_in,
  output kca_pkg::scan_t                scan_out
);

  logic [kca_pkg::KEY_W-1:0]  key;
  logic [kca_pkg::CNT_W-1:0]  cnt;
  logic [kca_pkg::USED_W-1:0] pos_u;
  logic                       live;
  logic                       is_last;
  logic                       match;
  logic                       rd_sel;
  logic                       take;
  kca_pkg::scan_t             scan_next;

  assign pos_u   = kca_pkg::USED_W'(pos);
  assign live    = pos_u < used;
  assign is_last = (pos_u + kca_pkg::USED_W'(1)) == used;
  assign match   = live && (key == query.key);
  assign rd_sel  = live && (kca_pkg::CMP_W'(pos) == kca_pkg::CMP_W'(query.ridx));

  always_comb begin
    unique case (query.op)
      kca_pkg::MODE_SEARCH: take = match && (is_last || !scan_in.found);
      kca_pkg::MODE_LAST:   take = match && is_last;
      kca_pkg::MODE_APPEND: take = 1'b0;
      kca_pkg::MODE_READ:   take = rd_sel;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    scan_next = scan_in;
    if (scan_in.valid && take) begin
      scan_next.found = 1'b1;
      scan_next.idx   = pos;
      scan_next.key   = key;
      scan_next.cnt   = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

  // entry storage, written only by the commit broadcast
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == pos)) begin
      key <= wr.key;
      cnt <= wr.cnt;
    end
  end

endmodule

FILE: src/keyed_count_accumulator_table.sv
// ----------------------------------------------------------------------------
// keyed_count_accumulator_table
// insertion-ordered table of (document id, count) pairs with search,
// last-entry accumulate, append and read requests
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, one per entry. Each request sends a
// scan token through the row, one cell per cycle; the cells compare their key
// (or their position, for a read) and the token leaves the far end carrying
// the winning entry. A single commit cycle then updates or appends the entry
// through a write broadcast, as the mode calls for, and loads the result
// register; the commit waits while the previous result is uncollected. The
// next request is taken as soon as the result is loaded, even if it has not
// been collected yet, and not before. In search mode the newest entry wins
// if it matches, otherwise the oldest matching one. Counts saturate at all
// ones, and an append into a full table is dropped with the full status.
// Entries beyond the fill count are never read, so the storage needs no reset.
// ----------------------------------------------------------------------------
module keyed_count_accumulator_table (
  input  logic      clk,
  input  logic      rst,
  kca_req_if.sink   req,
  kca_res_if.source res
);

  kca_pkg::state_t state;
  kca_pkg::state_t state_next;

  // request held for the whole scan
  kca_pkg::query_t               query;
  logic [kca_pkg::CNT_W-1:0]     req_amount;
  logic                          launch;

  // fill count
  logic [kca_pkg::USED_W-1:0]    used;
  logic [kca_pkg::USED_W-1:0]    used_next;

  // scan token at each cell boundary, and its latched copy at the far end
  kca_pkg::scan_t                chain [kca_pkg::TABLE_DEPTH+1];
  kca_pkg::scan_t                scan_end;

  kca_pkg::wr_t                  wr;

  logic                          accept;
  logic                          out_free;
  logic                          commit;
  logic                          append_sel;
  logic                          full;
  logic [kca_pkg::CNT_W:0]       sum;
  logic [kca_pkg::CNT_W-1:0]     bumped;

  // result register
  logic                          out_valid;
  kca_pkg::status_t              status_next;
  logic [kca_pkg::SLOT_W-1:0]    slot_next;
  logic [kca_pkg::KEY_W-1:0]     key_next;
  logic [kca_pkg::CNT_W-1:0]     cnt_next;
  kca_pkg::status_t              out_status;
  logic [kca_pkg::SLOT_W-1:0]    out_slot;
  logic [kca_pkg::KEY_W-1:0]     out_key;
  logic [kca_pkg::CNT_W-1:0]     out_cnt;
  logic [kca_pkg::TOTAL_W-1:0]   out_total;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      kca_pkg::S_IDLE:   if (req.valid) state_next = kca_pkg::S_SCAN;
      kca_pkg::S_SCAN:   if (chain[kca_pkg::TABLE_DEPTH].valid) state_next = kca_pkg::S_FINISH;
      kca_pkg::S_FINISH: if (out_free) state_next = kca_pkg::S_IDLE;
      default:           state_next = kca_pkg::S_IDLE;
    endcase
  end

  // result slot is free when empty or being collected this cycle
  always_comb begin
    out_free  = !out_valid || res.ready;
    req.ready = (state == kca_pkg::S_IDLE);
    accept    = req.valid && (state == kca_pkg::S_IDLE);
    commit    = (state == kca_pkg::S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kca_pkg::S_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query.op    <= kca_pkg::mode_t'(req.mode);
      query.key   <= req.doc_id;
      query.ridx  <= req.read_index;
      req_amount  <= req.amount;
    end
    if (chain[kca_pkg::TABLE_DEPTH].valid) begin
      scan_end <= chain[kca_pkg::TABLE_DEPTH];
    end
  end

  // ------------------------------------------------------------- cell row
  // token enters the first cell the cycle after acceptance
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  for (genvar i = 0; i < kca_pkg::TABLE_DEPTH; i++) begin : g_cell
    kca_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .pos      (kca_pkg::IDX_W'(i)),
      .used     (used),
      .query    (query),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  // ---------------------------------------------------------------- commit
  // saturating add for an update of an existing entry
  assign sum    = {1'b0, scan_end.cnt} + {1'b0, req_amount};
  assign bumped = sum[kca_pkg::CNT_W] ? '1 : sum[kca_pkg::CNT_W-1:0];
  assign full   = (used == kca_pkg::USED_W'(kca_pkg::TABLE_DEPTH));

  always_comb begin
    wr          = '0;
    append_sel  = 1'b0;
    used_next   = used;
    status_next = kca_pkg::ST_READ_BAD;
    slot_next   = kca_pkg::SLOT_W'(query.ridx);
    key_next    = '0;
    cnt_next    = '0;
    priority if (query.op == kca_pkg::MODE_READ) begin
      if (scan_end.found) begin
        status_next = kca_pkg::ST_READ_OK;
        key_next    = scan_end.key;
        cnt_next    = scan_end.cnt;
      end
    end else if (scan_end.found) begin
      // matching entry found: accumulate into it
      wr.en       = commit;
      wr.idx      = scan_end.idx;
      wr.key      = scan_end.key;
      wr.cnt      = bumped;
      status_next = kca_pkg::ST_UPDATED;
      slot_next   = kca_pkg::SLOT_W'(scan_end.idx);
      key_next    = scan_end.key;
      cnt_next    = bumped;
    end else if (full) begin
      // no room: drop, report the offered key
      status_next = kca_pkg::ST_FULL;
      slot_next   = '0;
      key_next    = query.key;
    end else begin
      append_sel  = 1'b1;
      wr.en       = commit;
      wr.idx      = kca_pkg::IDX_W'(used);
      wr.key      = query.key;
      wr.cnt      = req_amount;
      used_next   = used + kca_pkg::USED_W'(1);
      status_next = kca_pkg::ST_APPENDED;
      slot_next   = kca_pkg::SLOT_W'(used);
      key_next    = query.key;
      cnt_next    = req_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        used      <= used_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= status_next;
      out_slot   <= slot_next;
      out_key    <= key_next;
      out_cnt    <= cnt_next;
      out_total  <= kca_pkg::TOTAL_W'(used_next);
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.slot        = out_slot;
  assign res.doc_id_out  = out_key;
  assign res.count_out   = out_cnt;
  assign res.entry_total = out_total;

  // ------------------------------------------------------------- checks
  // fill count never passes the capacity
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= kca_pkg::USED_W'(kca_pkg::TABLE_DEPTH))
    else $error("fill count beyond capacity");

  // a token only leaves the row while a scan is running
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[kca_pkg::TABLE_DEPTH].valid |-> state == kca_pkg::S_SCAN)
    else $error("scan token outside scan");

  // an accepted request launches exactly one token
  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> launch && state == kca_pkg::S_SCAN)
    else $error("request accepted without launch");

  // an append grows the table by one entry
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    commit && append_sel |=> used == $past(used) + kca_pkg::USED_W'(1))
    else $error("append did not grow the table");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Exercises the keyed count accumulator table through its request and result
// channels. Every request is predicted at acceptance and every result is
// checked field by field, in order, against the prediction, while both sides
// idle, stall and hold off in turn.
// ----------------------------------------------------------------------------
module tb_top;

  // one request as offered on the request channel
  typedef struct {
    kca_pkg::mode_t                     op;
    logic [kca_pkg::KEY_W-1:0]          key;
    logic [kca_pkg::CNT_W-1:0]          amt;
    logic [kca_pkg::RIDX_W-1:0]         ridx;
  } term_t;

  // one predicted result
  typedef struct {
    kca_pkg::status_t                   status;
    logic [kca_pkg::SLOT_W-1:0]         slot;
    logic [kca_pkg::KEY_W-1:0]          key;
    logic [kca_pkg::CNT_W-1:0]          cnt;
    logic [kca_pkg::TOTAL_W-1:0]        total;
  } tally_t;

  logic clk = 1'b0;
  logic rst;

  kca_req_if req_ch ();
  kca_res_if res_ch ();

  keyed_count_accumulator_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // predicted table contents, updated as each request is accepted
  logic [kca_pkg::KEY_W-1:0] tally_keys   [kca_pkg::TABLE_DEPTH];
  logic [kca_pkg::CNT_W-1:0] tally_counts [kca_pkg::TABLE_DEPTH];
  int unsigned               tally_fill;

  // results still to come, oldest first
  tally_t pending_tallies [$];

  int unsigned fault_count;

  // idling knobs: percentages per request (sender) and per cycle (receiver)
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int unsigned hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  function automatic logic [kca_pkg::CNT_W-1:0] sat_sum(logic [kca_pkg::CNT_W-1:0] a,
                                                        logic [kca_pkg::CNT_W-1:0] b);
    logic [kca_pkg::CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[kca_pkg::CNT_W] ? {kca_pkg::CNT_W{1'b1}} : s[kca_pkg::CNT_W-1:0];
  endfunction

  // works out the result of one request and applies it to the predicted table
  function automatic tally_t predict_tally(term_t t);
    tally_t                    r;
    int                        hit;
    int                        newest;
    logic [kca_pkg::IDX_W-1:0] at;
    hit = -1;
    r.status = kca_pkg::ST_READ_BAD;
    r.slot   = '0;
    r.key    = '0;
    r.cnt    = '0;

    if (t.op == kca_pkg::MODE_READ) begin
      r.slot = t.ridx;
      if (t.ridx < tally_fill) begin
        at       = kca_pkg::IDX_W'(t.ridx);
        r.status = kca_pkg::ST_READ_OK;
        r.key    = tally_keys[at];
        r.cnt    = tally_counts[at];
      end
      r.total = kca_pkg::TOTAL_W'(tally_fill);
      return r;
    end

    // newest entry first, then (search only) the older ones from the bottom up
    if (t.op != kca_pkg::MODE_APPEND && tally_fill > 0) begin
      newest = int'(tally_fill) - 1;
      if (tally_keys[kca_pkg::IDX_W'(newest)] == t.key) begin
        hit = newest;
      end else if (t.op == kca_pkg::MODE_SEARCH) begin
        for (int i = 0; i < newest; i++) begin
          if (hit < 0 && tally_keys[kca_pkg::IDX_W'(i)] == t.key) hit = i;
        end
      end
    end

    if (hit >= 0) begin
      at               = kca_pkg::IDX_W'(hit);
      tally_counts[at] = sat_sum(tally_counts[at], t.amt);
      r.status = kca_pkg::ST_UPDATED;
      r.slot   = kca_pkg::SLOT_W'(hit);
      r.key    = tally_keys[at];
      r.cnt    = tally_counts[at];
    end else if (tally_fill >= kca_pkg::TABLE_DEPTH) begin
      // full table: dropped, nothing changes
      r.status = kca_pkg::ST_FULL;
      r.key    = t.key;
    end else begin
      at               = kca_pkg::IDX_W'(tally_fill);
      tally_keys[at]   = t.key;
      tally_counts[at] = t.amt;
      r.status = kca_pkg::ST_APPENDED;
      r.slot   = kca_pkg::SLOT_W'(tally_fill);
      r.key    = t.key;
      r.cnt    = t.amt;
      tally_fill++;
    end
    r.total = kca_pkg::TOTAL_W'(tally_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offers one request, holds it until accepted, then records its prediction;
  // valid stays high on return so that back-to-back requests need no toggle
  task automatic offer_term(input term_t t);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      // gaps long enough to land anywhere in the row walk
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= t.op;
    req_ch.doc_id     <= t.key;
    req_ch.amount     <= t.amt;
    req_ch.read_index <= t.ridx;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    pending_tallies.push_back(predict_tally(t));
  endtask

  task automatic offer_fields(input kca_pkg::mode_t op,
                              input logic [kca_pkg::KEY_W-1:0] key,
                              input logic [kca_pkg::CNT_W-1:0] amt,
                              input logic [kca_pkg::RIDX_W-1:0] ridx);
    term_t t;
    t.op   = op;
    t.key  = key;
    t.amt  = amt;
    t.ridx = ridx;
    offer_term(t);
  endtask

  // drops valid and waits until every outstanding result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  // knobs change on the falling edge so the receiver never races them
  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // random content
  // --------------------------------------------------------------------------

  function automatic logic [kca_pkg::CNT_W-1:0] roll_amount();
    case ($urandom_range(19))
      0:       return '0;
      1, 2:    return {kca_pkg::CNT_W{1'b1}};
      3, 4, 5: return {kca_pkg::CNT_W{1'b1}} - kca_pkg::CNT_W'($urandom_range(0, 255));
      6, 7, 8: return kca_pkg::CNT_W'($urandom);
      default: return kca_pkg::CNT_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [kca_pkg::KEY_W-1:0] roll_fresh_key();
    case ($urandom_range(19))
      0:       return '0;
      1:       return {kca_pkg::KEY_W{1'b1}};
      default: return kca_pkg::KEY_W'($urandom);
    endcase
  endfunction

  // grow_pct steers how often a request can add an entry, so the table fills
  // slowly early on and the search paths see a long run of part-full tables
  function automatic term_t roll_term(int unsigned grow_pct);
    term_t t;
    bit    fresh;
    if ($urandom_range(99) < grow_pct) begin
      t.op = kca_pkg::MODE_APPEND;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: t.op = kca_pkg::MODE_SEARCH;
        4, 5, 6:    t.op = kca_pkg::MODE_LAST;
        default:    t.op = kca_pkg::MODE_READ;
      endcase
    end
    t.amt  = roll_amount();
    t.ridx = kca_pkg::RIDX_W'($urandom_range(0, 63));
    // reads aim inside the filled part about half the time
    if (t.op == kca_pkg::MODE_READ && tally_fill > 0 && $urandom_range(1) == 1)
      t.ridx = kca_pkg::RIDX_W'($urandom_range(0, tally_fill - 1));

    fresh = (tally_fill == 0) || ($urandom_range(99) < grow_pct);
    if (fresh || t.op == kca_pkg::MODE_READ)
      t.key = roll_fresh_key();
    else if (t.op == kca_pkg::MODE_LAST)
      t.key = tally_keys[kca_pkg::IDX_W'(tally_fill - 1)];
    else
      // existing key: a hit for search, a duplicate entry for append
      t.key = tally_keys[kca_pkg::IDX_W'($urandom_range(0, tally_fill - 1))];
    return t;
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned grow_pct);
    repeat (n) offer_term(roll_term(grow_pct));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_directed_cases();
    // empty table: read misses, both accumulate modes append
    offer_fields(kca_pkg::MODE_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
    offer_fields(kca_pkg::MODE_LAST,   32'h0000_0000, 32'h0000_0000, 6'd63);
    offer_fields(kca_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    // newest entry hit, count already at all ones stays there
    offer_fields(kca_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 32'h0000_0001, 6'd0);
    // plain append of a key already held gives a duplicate
    offer_fields(kca_pkg::MODE_APPEND, 32'h0000_0000, 32'h0000_0005, 6'd21);
    // newest of the duplicates is checked first
    offer_fields(kca_pkg::MODE_SEARCH, 32'h0000_0000, 32'h0000_0007, 6'd42);
    offer_fields(kca_pkg::MODE_APPEND, 32'hA5A5_A5A5, 32'h0000_000A, 6'd0);
    // older entries scanned from slot 0 upward: first duplicate wins
    offer_fields(kca_pkg::MODE_SEARCH, 32'h0000_0000, 32'h0000_0003, 6'd0);
    // last-entry mode ignores an older match and appends
    offer_fields(kca_pkg::MODE_LAST,   32'hFFFF_FFFF, 32'h0000_0002, 6'd0);
    // lands exactly on all ones, then one more saturates
    offer_fields(kca_pkg::MODE_LAST,   32'hFFFF_FFFF, 32'hFFFF_FFFD, 6'd0);
    offer_fields(kca_pkg::MODE_LAST,   32'hFFFF_FFFF, 32'h0000_0001, 6'd0);
    offer_fields(kca_pkg::MODE_SEARCH, 32'h5A5A_5A5A, 32'h0000_0000, 6'd0);
    // older entry hit in the middle of the table
    offer_fields(kca_pkg::MODE_SEARCH, 32'hA5A5_A5A5, 32'h8000_0000, 6'd0);
    for (int i = 0; i < 6; i++) begin
      offer_fields(kca_pkg::MODE_READ, 32'h0, 32'h0, kca_pkg::RIDX_W'(i));
    end
    // reads at and beyond the fill count
    offer_fields(kca_pkg::MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd6);
    offer_fields(kca_pkg::MODE_READ, 32'h0, 32'h0, 6'd63);
    offer_fields(kca_pkg::MODE_READ, 32'h0, 32'h0, 6'd42);
    offer_fields(kca_pkg::MODE_READ, 32'h0, 32'h0, 6'd21);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    set_idling(0, 0);
    run_random(410, 3);
  endtask

  task automatic test_random_sender_idle();
    set_idling(61, 0);
    run_random(410, 3);
  endtask

  // receiver holds off long enough for the result register to fill and the
  // next scan to wait on it, so requests stall while the sender keeps offering
  task automatic test_receiver_hold();
    set_idling(0, 0);
    @(negedge clk);
    hold_left = 600;
    @(posedge clk);
    run_random(6, 10);
  endtask

  // sender stops mid-stream until everything has come back, then carries on
  task automatic test_drain_pause();
    set_idling(0, 36);
    repeat (4) offer_term(roll_term(5));
    wait_drained();
    repeat (4) offer_term(roll_term(5));
    wait_drained();
  endtask

  task automatic test_table_full();
    logic [kca_pkg::KEY_W-1:0] key;
    set_idling(0, 0);
    while (tally_fill < kca_pkg::TABLE_DEPTH) begin
      offer_fields(kca_pkg::MODE_APPEND, roll_fresh_key(), roll_amount(), 6'd0);
    end
    // every way of adding an entry is now dropped
    repeat (3) offer_fields(kca_pkg::MODE_APPEND, roll_fresh_key(), roll_amount(), 6'd0);
    key = 32'h1234_5678;
    offer_fields(kca_pkg::MODE_SEARCH, key, 32'h0000_0001, 6'd0);
    offer_fields(kca_pkg::MODE_LAST,   key, 32'h0000_0001, 6'd0);
    // top slot now readable, searches still hit the oldest and newest entries
    offer_fields(kca_pkg::MODE_READ,   32'h0, 32'h0, 6'd63);
    offer_fields(kca_pkg::MODE_SEARCH, tally_keys[0], 32'h0000_0001, 6'd0);
    offer_fields(kca_pkg::MODE_SEARCH, tally_keys[kca_pkg::TABLE_DEPTH-1],
                 32'h0000_0001, 6'd0);
    wait_drained();
  endtask

  task automatic test_random_receiver_stall();
    set_idling(0, 61);
    run_random(410, 10);
  endtask

  task automatic test_random_both_idle();
    set_idling(36, 36);
    run_random(410, 10);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // receiver: random stalls, or a counted hold-off when one is asked for
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      fault_count++;
    end
  endfunction

  // every collected result is compared with the oldest prediction
  always @(posedge clk) begin
    tally_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t result with no request outstanding: status %0d slot %0d key %h",
                 $time, res_ch.status, res_ch.slot, res_ch.doc_id_out);
        fault_count++;
      end else begin
        want = pending_tallies.pop_front();
        check_field("status",      32'(want.status), 32'(res_ch.status));
        check_field("slot",        32'(want.slot),   32'(res_ch.slot));
        check_field("doc_id_out",  want.key,         res_ch.doc_id_out);
        check_field("count_out",   want.cnt,         res_ch.count_out);
        check_field("entry_total", 32'(want.total),  32'(res_ch.entry_total));
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence of tests
  // --------------------------------------------------------------------------

  initial begin
    fault_count    = 0;
    tally_fill     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= kca_pkg::MODE_SEARCH;
    req_ch.doc_id     <= '0;
    req_ch.amount     <= '0;
    req_ch.read_index <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_no_idle();
    test_receiver_hold();
    test_random_sender_idle();
    test_drain_pause();
    test_table_full();
    test_random_receiver_stall();
    test_random_both_idle();

    // allow a full row walk for any stray result to show up
    wait_drained();
    repeat (kca_pkg::TABLE_DEPTH + 8) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: keyed_count_accumulator_table.f
src/kca_pkg.sv
src/kca_if.sv
src/kca_cell.sv
src/keyed_count_accumulator_table.sv
sim/tb_top.sv
